FILE: hdl/gmrhp_pkg.sv
// shared types and codes for the gemini response header parser
// no dependencies; imported by the front, queue, back and top level
package gmrhp_pkg;

   // request types
   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_META     = 2'd0;
   localparam logic [1:0] KIND_BODY     = 2'd1;
   localparam logic [1:0] KIND_OUTCOME  = 2'd2;
   localparam logic [1:0] KIND_COMPLETE = 2'd3;

   // header outcomes
   localparam logic [3:0] OC_VIOLATION = 4'd0;
   localparam logic [3:0] OC_INPUT     = 4'd1;
   localparam logic [3:0] OC_SUCCESS   = 4'd2;
   localparam logic [3:0] OC_REDIRECT  = 4'd3;
   localparam logic [3:0] OC_TEMPORARY = 4'd4;
   localparam logic [3:0] OC_PERMANENT = 4'd5;
   localparam logic [3:0] OC_CERT_TRANS = 4'd6;
   localparam logic [3:0] OC_CERT_AUTH  = 4'd7;
   localparam logic [3:0] OC_CERT_REJ   = 4'd8;

   // violation details
   localparam logic [2:0] DET_NONE      = 3'd0;
   localparam logic [2:0] DET_SHORT     = 3'd0;
   localparam logic [2:0] DET_NO_CR     = 3'd1;
   localparam logic [2:0] DET_BAD_FIRST = 3'd2;
   localparam logic [2:0] DET_BAD_SECOND = 3'd3;
   localparam logic [2:0] DET_BAD_THIRD = 3'd4;
   localparam logic [2:0] DET_BAD_CLASS = 3'd5;
   localparam logic [2:0] DET_BAD_REQUEST = 3'd4;

   // redirect detail: second digit 1 marks a permanent redirect
   localparam logic [2:0] DET_REDIR_PERM = 3'd1;

   // characters and limits
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam int unsigned MinLen  = 5;

   // command queue depth
   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW  = $clog2(QDepth);

   // one queued command: an optional held cr ahead of an optional main result
   typedef struct packed {
      logic       prefix_cr;
      logic       has_main;
      logic [1:0] kind;
      logic [7:0] data;
      logic [3:0] outcome;
      logic [2:0] detail;
      logic [6:0] status;
   } cmd_type;

endpackage

FILE: hdl/gmrhp_front.sv
// front end: accepts requests, tracks the header line and judges it at lf
// depends on gmrhp_pkg; feeds commands into gmrhp_queue
module gmrhp_front
   import gmrhp_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       q_full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   output logic       push,
   output cmd_type    push_cmd
);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_BODY   = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [3:0] outcome;
      logic [2:0] detail;
      logic [6:0] status;
      logic       to_body;
   } verdict_type;

   localparam logic [LEN_WIDTH-1:0] LenMax = {LEN_WIDTH{1'b1}};
   localparam logic [LEN_WIDTH-1:0] LenMin = LEN_WIDTH'(MinLen);
   localparam logic [LEN_WIDTH-1:0] Pos1   = LEN_WIDTH'(1);
   localparam logic [LEN_WIDTH-1:0] Pos2   = LEN_WIDTH'(2);

   phase_type            phase_ff, phase_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic [7:0]           c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic                 lcr_ff, lcr_in;
   logic                 crh_ff, crh_in;
   logic                 accept;
   verdict_type          verdict;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // header verdict from the saved line state
   function automatic verdict_type judge(input logic long_enough, input logic cr_seen,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      verdict_type v;
      logic [3:0]  hi;
      logic [3:0]  lo;
      v  = '0;
      hi = a[3:0];
      lo = b[3:0];
      if (!long_enough) begin
         v.detail = DET_SHORT;
      end else if (!cr_seen) begin
         v.detail = DET_NO_CR;
      end else if (!is_digit(a)) begin
         v.detail = DET_BAD_FIRST;
      end else if (!is_digit(b)) begin
         v.detail = DET_BAD_SECOND;
      end else if (!is_space(c)) begin
         v.detail = DET_BAD_THIRD;
      end else begin
         // hi*10 + lo by shift and add
         v.status = 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
         unique case (hi)
            4'd1: v.outcome = OC_INPUT;
            4'd2: begin
               v.outcome = OC_SUCCESS;
               v.to_body = 1'b1;
            end
            4'd3: begin
               v.outcome = OC_REDIRECT;
               v.detail  = (lo == 4'd1) ? DET_REDIR_PERM : DET_NONE;
            end
            4'd4: begin
               v.outcome = OC_TEMPORARY;
               v.detail  = (lo >= 4'd1 && lo <= 4'd4) ? lo[2:0] : DET_NONE;
            end
            4'd5: begin
               v.outcome = OC_PERMANENT;
               if (lo >= 4'd1 && lo <= 4'd3) v.detail = lo[2:0];
               else if (lo == 4'd9)          v.detail = DET_BAD_REQUEST;
               else                          v.detail = DET_NONE;
            end
            4'd6: begin
               if (lo == 4'd1) begin
                  v.outcome = OC_CERT_TRANS;
               end else if (lo == 4'd2) begin
                  v.outcome = OC_CERT_AUTH;
               end else begin
                  v.outcome = OC_CERT_REJ;
                  v.detail  = (lo >= 4'd3 && lo <= 4'd5) ? 3'(lo - 4'd2) : DET_NONE;
               end
            end
            default: begin
               v.outcome = OC_VIOLATION;
               v.detail  = DET_BAD_CLASS;
            end
         endcase
      end
      return v;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign verdict   = judge(len_ff > LenMin, lcr_ff, c1_ff, c2_ff, c3_ff);

   // request classification and header tracking
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      c3_in    = c3_ff;
      lcr_in   = lcr_ff;
      crh_in   = crh_ff;
      push_cmd = '0;
      if (accept) begin
         unique case (req_type)
            REQ_START: begin
               if (phase_ff == PH_IDLE || phase_ff == PH_DONE) begin
                  phase_in = PH_HEADER;
                  len_in   = '0;
                  c1_in    = '0;
                  c2_in    = '0;
                  c3_in    = '0;
                  lcr_in   = 1'b0;
                  crh_in   = 1'b0;
               end
            end
            REQ_CLOSE: begin
               if (phase_ff == PH_BODY) begin
                  push_cmd.has_main = 1'b1;
                  push_cmd.kind     = KIND_COMPLETE;
               end
               phase_in = PH_IDLE;
            end
            REQ_BYTE: begin
               if (phase_ff == PH_BODY) begin
                  push_cmd.has_main = 1'b1;
                  push_cmd.kind     = KIND_BODY;
                  push_cmd.data     = req_rx_byte;
               end else if (phase_ff == PH_HEADER) begin
                  if (req_rx_byte == CH_LF) begin
                     phase_in          = verdict.to_body ? PH_BODY : PH_DONE;
                     crh_in            = 1'b0;
                     push_cmd.has_main = 1'b1;
                     push_cmd.kind     = KIND_OUTCOME;
                     push_cmd.outcome  = verdict.outcome;
                     push_cmd.detail   = verdict.detail;
                     push_cmd.status   = verdict.status;
                  end else begin
                     if (len_ff == '0) begin
                        c1_in = req_rx_byte;
                     end else if (len_ff == Pos1) begin
                        c2_in = req_rx_byte;
                     end else if (len_ff == Pos2) begin
                        c3_in = req_rx_byte;
                     end else begin
                        // meta byte: release any held cr, hold a new one
                        push_cmd.prefix_cr = crh_ff;
                        if (req_rx_byte == CH_CR) begin
                           crh_in = 1'b1;
                        end else begin
                           crh_in            = 1'b0;
                           push_cmd.has_main = 1'b1;
                           push_cmd.kind     = KIND_META;
                           push_cmd.data     = req_rx_byte;
                        end
                     end
                     lcr_in = (req_rx_byte == CH_CR);
                     if (len_ff != LenMax) len_in = len_ff + Pos1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push = push_cmd.prefix_cr || push_cmd.has_main;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         c1_ff    <= '0;
         c2_ff    <= '0;
         c3_ff    <= '0;
         lcr_ff   <= 1'b0;
         crh_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
         c3_ff    <= c3_in;
         lcr_ff   <= lcr_in;
         crh_ff   <= crh_in;
      end
   end

   // a held cr is set in the header phase and may linger into idle after a close,
   // but lf always drops it before the body or done phases
   assert property (@(posedge clock) disable iff (reset)
      crh_ff |-> (phase_ff == PH_HEADER || phase_ff == PH_IDLE))
      else $error("held cr outside header or idle phase");

endmodule

FILE: hdl/gmrhp_queue.sv
// short command queue between the front end and the result back end
// depends on gmrhp_pkg for the command type and depth
module gmrhp_queue
   import gmrhp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   localparam logic [QPtrW:0]   CntDepth = (QPtrW + 1)'(QDepth);
   localparam logic [QPtrW-1:0] PtrLast  = QPtrW'(QDepth - 1);

   cmd_type          entry_ff [QDepth];
   logic [QPtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPtrW:0]   cnt_ff, cnt_in;
   logic             do_pop;

   assign full      = (cnt_ff == CntDepth);
   assign not_empty = (cnt_ff != '0);
   assign head      = entry_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
      if (push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_cmd;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CntDepth)
      else $error("queue count over depth");

endmodule

FILE: hdl/gmrhp_back.sv
// back end: expands each queued command into one or two results
// depends on gmrhp_pkg; reads the head of gmrhp_queue
module gmrhp_back
   import gmrhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       not_empty,
   input  cmd_type    head,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_outcome,
   output logic [2:0] rsp_detail,
   output logic [6:0] rsp_status_digits,
   output logic       rsp_last_of_run
);

   logic sub_ff, sub_in;
   logic on_prefix;
   logic taken;

   assign rsp_valid = not_empty;
   assign on_prefix = head.prefix_cr && !sub_ff;
   assign taken     = rsp_valid && !rsp_stall;

   // result selection: held cr first, then the main result
   always_comb begin
      if (on_prefix) begin
         rsp_out_kind      = KIND_META;
         rsp_out_byte      = CH_CR;
         rsp_outcome       = OC_VIOLATION;
         rsp_detail        = DET_NONE;
         rsp_status_digits = '0;
         rsp_last_of_run   = !head.has_main;
      end else begin
         rsp_out_kind      = head.kind;
         rsp_out_byte      = head.data;
         rsp_outcome       = head.outcome;
         rsp_detail        = head.detail;
         rsp_status_digits = head.status;
         rsp_last_of_run   = 1'b1;
      end
   end

   // step through the command, pop after its last result
   always_comb begin
      sub_in = sub_ff;
      pop    = 1'b0;
      if (taken) begin
         if (on_prefix && head.has_main) begin
            sub_in = 1'b1;
         end else begin
            sub_in = 1'b0;
            pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sub_ff <= 1'b0;
      else       sub_ff <= sub_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (not_empty && head.prefix_cr && head.has_main))
      else $error("second result without a two-result command");

endmodule

FILE: hdl/gemini_response_header_parser.sv
// gemini response header parser: one request per cycle while req_stall is low,
// results one per cycle while rsp_stall is low, each from the command queue head
// a meta byte other than cr that releases a held cr gives two results, cr first
// the four-entry command queue between front and back sets when req_stall rises
// synchronous active-high reset returns to idle with an empty queue
module gemini_response_header_parser
   import gmrhp_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_outcome,
   output logic [2:0] rsp_detail,
   output logic [6:0] rsp_status_digits,
   output logic       rsp_last_of_run
);

   logic    push, pop, full, not_empty;
   cmd_type push_cmd, head;

   // request classification
   gmrhp_front #(.LEN_WIDTH(LEN_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .q_full     (full),
      .req_type   (req_type),
      .req_rx_byte(req_rx_byte),
      .req_stall  (req_stall),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // command queue
   gmrhp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .not_empty(not_empty),
      .head     (head)
   );

   // result generation
   gmrhp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_outcome      (rsp_outcome),
      .rsp_detail       (rsp_detail),
      .rsp_status_digits(rsp_status_digits),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
